// ===== rtl/dbir_pkg.sv =====
package dbir_pkg;

    // Default sizing of the block store
    localparam int MAX_CHANNELS_DEF    = 8;
    localparam int MAX_BLOCK_BYTES_DEF = 4096;
    localparam int MAX_STEP_DEF        = 8;

    localparam int BYTE_W = 8;

    // Register field widths
    localparam int FC_W  = 4;
    localparam int BS_W  = 13;
    localparam int OC_W  = 4;
    localparam int ST_W  = 4;
    localparam int DL_W  = 48;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [FC_W-1:0] FC_RST = 4'd2;
    localparam logic [BS_W-1:0] BS_RST = 13'd4096;
    localparam logic [OC_W-1:0] OC_RST = 4'd2;
    localparam logic [ST_W-1:0] ST_RST = 4'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILE_CH    = 3'd0,
        CFG_BLOCK_SIZE = 3'd1,
        CFG_OUT_CH     = 3'd2,
        CFG_STEP       = 3'd3,
        CFG_DESC       = 3'd4,
        CFG_BREV       = 3'd5,
        CFG_DATA_LEN   = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_READ = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_BLOCK    = 2'd1,
        ST_END_OF_DATA = 2'd2
    } t_status;

    // Status from the frame sequencer to the top level
    typedef struct packed {
        logic busy;     // frame read in progress
        logic consume;  // the block was read to its end
    } t_seq_stat;

endpackage

// ===== rtl/dbir_ram.sv =====
module dbir_ram #(
    parameter int WIDTH = dbir_pkg::BYTE_W,
    parameter int DEPTH = dbir_pkg::MAX_CHANNELS_DEF * dbir_pkg::MAX_BLOCK_BYTES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dbir_seq.sv =====
module dbir_seq #(
    parameter int MAX_CHANNELS    = dbir_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_BLOCK_BYTES = dbir_pkg::MAX_BLOCK_BYTES_DEF,
    parameter int MAX_STEP        = dbir_pkg::MAX_STEP_DEF,
    parameter int AW  = $clog2(MAX_CHANNELS * MAX_BLOCK_BYTES),
    parameter int BW  = $clog2(MAX_BLOCK_BYTES + 1),
    parameter int CW  = $clog2(MAX_CHANNELS + 1),
    parameter int STW = $clog2(MAX_STEP + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_block_ready,
    input  logic [CW-1:0]                i_oc,
    input  logic [STW-1:0]               i_st,
    input  logic [BW-1:0]                i_bs,
    input  logic [AW:0]                  i_total,
    input  logic                         i_desc,
    input  logic                         i_brev,
    input  logic [dbir_pkg::DL_W-1:0]    i_dlen,
    output logic                         o_rd_en,
    output logic [AW-1:0]                o_rd_addr,
    input  logic [dbir_pkg::BYTE_W-1:0]  i_rd_data,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [dbir_pkg::BYTE_W-1:0]  o_m_tdata,
    output logic [1:0]                   o_m_tuser,
    output logic                         o_m_tlast,
    output dbir_pkg::t_seq_stat          o_stat
);

    import dbir_pkg::*;

    localparam int SW    = $clog2(MAX_BLOCK_BYTES + MAX_STEP);
    localparam int CMP_W = DL_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_RUN,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        t_status           code;
        logic              last;
    } t_beat;

    function automatic logic [BYTE_W-1:0] flip_bits(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        for (int k = 0; k < BYTE_W; k++) begin
            r[BYTE_W-1-k] = b[k];
        end
        return r;
    endfunction

    t_state              r_state, n_state;
    logic [BW-1:0]       r_rp, n_rp;
    logic [DL_W-1:0]     r_cons, n_cons;
    logic [CW-1:0]       r_ch, n_ch;
    logic [STW-1:0]      r_j, n_j;
    logic [AW-1:0]       r_base, n_base;
    logic                r_pend, n_pend;
    logic                r_pend_zero, n_pend_zero;
    logic                r_pend_last, n_pend_last;
    logic [1:0]          r_cnt, n_cnt;
    logic                r_wr_ptr, n_wr_ptr;
    logic                r_rd_ptr, n_rd_ptr;
    t_beat               r_q [2];

    logic                w_pop, w_space, w_push, w_push_st, w_issue, w_consume;
    logic [2:0]          w_occ;
    t_status             w_code;
    t_beat               w_beat;
    logic [STW-1:0]      w_k;
    logic [SW-1:0]       w_seg, w_rp_nx;
    logic                w_seg_ok, w_last_j, w_last_ch, w_end;
    logic [CMP_W-1:0]    w_pos;
    logic [BYTE_W-1:0]   w_byte;

    // Two-entry output buffer; a read is issued only when its beat has room
    assign w_pop   = (r_cnt != 2'd0) && i_m_tready;
    assign w_occ   = 3'(r_cnt) + 3'(r_pend) - 3'(w_pop);
    assign w_space = w_occ < 3'd2;

    // Shared address path: segment base plus offset in the segment
    assign w_k       = i_desc ? (i_st - STW'(1) - r_j) : r_j;
    assign w_seg     = SW'(r_rp) + SW'(w_k);
    assign w_seg_ok  = w_seg < SW'(i_bs);
    assign w_last_j  = r_j == i_st - STW'(1);
    assign w_last_ch = r_ch == i_oc - CW'(1);
    assign w_rp_nx   = SW'(r_rp) + SW'(i_st);

    assign w_pos = {1'b0, r_cons} + CMP_W'(r_rp);
    assign w_end = (i_dlen != '0) && (w_pos >= {1'b0, i_dlen});

    assign o_rd_en   = w_issue && w_seg_ok;
    assign o_rd_addr = r_base + AW'(w_seg);

    always_comb begin
        n_state     = r_state;
        n_rp        = r_rp;
        n_cons      = r_cons;
        n_ch        = r_ch;
        n_j         = r_j;
        n_base      = r_base;
        n_pend      = 1'b0;
        n_pend_zero = r_pend_zero;
        n_pend_last = r_pend_last;
        w_push_st   = 1'b0;
        w_code      = ST_OK;
        w_issue     = 1'b0;
        w_consume   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_CHECK;
                    n_ch    = '0;
                    n_j     = '0;
                    n_base  = '0;
                end
            end
            S_CHECK: begin
                if (!i_block_ready) begin
                    w_code = ST_NO_BLOCK;
                    if (w_space) begin
                        w_push_st = 1'b1;
                        n_state   = S_IDLE;
                    end
                end else if (w_end) begin
                    w_code = ST_END_OF_DATA;
                    if (w_space) begin
                        w_push_st = 1'b1;
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_space) begin
                    w_issue     = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_zero = !w_seg_ok;
                    n_pend_last = w_last_j && w_last_ch;
                    if (w_last_j) begin
                        n_j    = '0;
                        n_ch   = r_ch + CW'(1);
                        n_base = r_base + AW'(i_bs);
                        if (w_last_ch) begin
                            // Frame done: advance the position, wrap at block end
                            n_state = S_DRAIN;
                            if (w_rp_nx >= SW'(i_bs)) begin
                                n_rp      = '0;
                                w_consume = 1'b1;
                                n_cons    = r_cons + DL_W'(i_total);
                            end else begin
                                n_rp = BW'(w_rp_nx);
                            end
                        end
                    end else begin
                        n_j = r_j + STW'(1);
                    end
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_byte = r_pend_zero ? '0 : i_rd_data;
    assign w_push = r_pend || w_push_st;

    always_comb begin
        if (r_pend) begin
            w_beat.data = i_brev ? flip_bits(w_byte) : w_byte;
            w_beat.code = ST_OK;
            w_beat.last = r_pend_last;
        end else begin
            w_beat.data = '0;
            w_beat.code = w_code;
            w_beat.last = 1'b1;
        end
    end

    assign n_cnt    = r_cnt + 2'(w_push) - 2'(w_pop);
    assign n_wr_ptr = r_wr_ptr ^ w_push;
    assign n_rd_ptr = r_rd_ptr ^ w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rp        <= '0;
            r_cons      <= '0;
            r_ch        <= '0;
            r_j         <= '0;
            r_base      <= '0;
            r_pend      <= 1'b0;
            r_pend_zero <= 1'b0;
            r_pend_last <= 1'b0;
            r_cnt       <= '0;
            r_wr_ptr    <= 1'b0;
            r_rd_ptr    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rp        <= n_rp;
            r_cons      <= n_cons;
            r_ch        <= n_ch;
            r_j         <= n_j;
            r_base      <= n_base;
            r_pend      <= n_pend;
            r_pend_zero <= n_pend_zero;
            r_pend_last <= n_pend_last;
            r_cnt       <= n_cnt;
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
        end
        if (w_push) begin
            r_q[r_wr_ptr] <= w_beat;
        end
    end

    assign o_m_tvalid     = r_cnt != 2'd0;
    assign o_m_tdata      = r_q[r_rd_ptr].data;
    assign o_m_tuser      = r_q[r_rd_ptr].code;
    assign o_m_tlast      = r_q[r_rd_ptr].last;
    assign o_stat.busy    = r_state != S_IDLE;
    assign o_stat.consume = w_consume;

endmodule

// ===== rtl/dsd_block_to_interleaved_reorder.sv =====
// Channel-blocked DSD to interleaved frame reorder.
//
// Input stream (i_s_*): one beat is one command. tuser = opcode (load or read),
// tdata = data byte. A load appends the byte to the block store; once
// file_channels * block_size bytes are in, the block is ready and further
// loads are dropped until it is consumed.
// A read emits one frame on the output stream (o_m_*): tdata = byte,
// tuser = status, tlast marks the final beat of the frame. With no ready block,
// or at or past data_length, the frame is a single beat with a nonzero status.
// Otherwise it holds out_channels * interleave_step bytes.
// Timing: a read holds the input while the sequencer checks the block, then walks
// channels and steps through one address adder and the single store read port,
// one byte per cycle while the output buffer has room. Each byte passes the
// store read register into the output buffer; a status-only frame is written
// to the buffer from the check step.
// Results pass through a two-beat output buffer; when the receiver stalls the
// sequencer stops issuing store reads and resumes once a slot frees up.
// Configuration (i_cfg_*) is always ready; write it only while idle.
// Reset: registers take their defaults, the block is empty and the read
// position and consumed offset are zero. The store itself is not cleared.
module dsd_block_to_interleaved_reorder #(
    parameter int MAX_CHANNELS    = dbir_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_BLOCK_BYTES = dbir_pkg::MAX_BLOCK_BYTES_DEF,
    parameter int MAX_STEP        = dbir_pkg::MAX_STEP_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dbir_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [dbir_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // command stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [7:0]                       i_s_tdata,   // [7:0] data_byte
    input  logic                             i_s_tuser,   // [0] opcode
    // frame stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [7:0]                       o_m_tdata,   // [7:0] out_byte
    output logic [1:0]                       o_m_tuser,   // [1:0] status
    output logic                             o_m_tlast    // last beat of frame
);

    import dbir_pkg::*;

    localparam int DEPTH = MAX_CHANNELS * MAX_BLOCK_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int CW    = $clog2(MAX_CHANNELS + 1);
    localparam int STW   = $clog2(MAX_STEP + 1);
    localparam int PW    = CW + BW;

    // Configuration registers
    logic [FC_W-1:0] r_file_ch;
    logic [BS_W-1:0] r_blk_size;
    logic [OC_W-1:0] r_out_ch;
    logic [ST_W-1:0] r_step;
    logic            r_desc;
    logic            r_brev;
    logic [DL_W-1:0] r_dlen;

    // Block fill state
    logic [AW-1:0]   r_load_cnt, n_load_cnt;
    logic            r_block_ready, n_block_ready;

    logic [CW-1:0]   w_fc, w_oc;
    logic [BW-1:0]   w_bs;
    logic [STW-1:0]  w_st;
    logic [PW-1:0]   w_prod;
    logic [AW:0]     w_total, w_cnt_inc;
    logic            w_s_acc, w_load, w_start;
    logic            w_rd_en;
    logic [AW-1:0]   w_rd_addr;
    logic [BYTE_W-1:0] w_rd_data;
    t_seq_stat       w_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_ch  <= FC_RST;
            r_blk_size <= BS_RST;
            r_out_ch   <= OC_RST;
            r_step     <= ST_RST;
            r_desc     <= 1'b0;
            r_brev     <= 1'b0;
            r_dlen     <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_FILE_CH:    r_file_ch  <= i_cfg_data[FC_W-1:0];
                CFG_BLOCK_SIZE: r_blk_size <= i_cfg_data[BS_W-1:0];
                CFG_OUT_CH:     r_out_ch   <= i_cfg_data[OC_W-1:0];
                CFG_STEP:       r_step     <= i_cfg_data[ST_W-1:0];
                CFG_DESC:       r_desc     <= i_cfg_data[0];
                CFG_BREV:       r_brev     <= i_cfg_data[0];
                CFG_DATA_LEN:   r_dlen     <= i_cfg_data[DL_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate the geometry registers into their legal ranges
    always_comb begin
        if (r_file_ch == '0) begin
            w_fc = CW'(1);
        end else if (32'(r_file_ch) > MAX_CHANNELS) begin
            w_fc = CW'(MAX_CHANNELS);
        end else begin
            w_fc = CW'(r_file_ch);
        end

        if (r_blk_size == '0) begin
            w_bs = BW'(1);
        end else if (32'(r_blk_size) > MAX_BLOCK_BYTES) begin
            w_bs = BW'(MAX_BLOCK_BYTES);
        end else begin
            w_bs = BW'(r_blk_size);
        end

        // out_channels never exceeds the channels stored per block
        if (r_out_ch == '0) begin
            w_oc = CW'(1);
        end else if (32'(r_out_ch) > 32'(w_fc)) begin
            w_oc = w_fc;
        end else begin
            w_oc = CW'(r_out_ch);
        end

        if (r_step == '0) begin
            w_st = STW'(1);
        end else if (32'(r_step) > MAX_STEP) begin
            w_st = STW'(MAX_STEP);
        end else begin
            w_st = STW'(r_step);
        end
    end

    // Bytes per block; never above the store depth
    assign w_prod  = PW'(w_fc) * PW'(w_bs);
    assign w_total = (AW + 1)'(w_prod);

    assign o_s_tready = !w_stat.busy;
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_load     = w_s_acc && (t_opcode'(i_s_tuser) == OP_LOAD) && !r_block_ready;
    assign w_start    = w_s_acc && (t_opcode'(i_s_tuser) == OP_READ);
    assign w_cnt_inc  = (AW + 1)'(r_load_cnt) + (AW + 1)'(1);

    // Fill count: mark the block ready once it is full; drop loads while ready
    always_comb begin
        n_load_cnt    = r_load_cnt;
        n_block_ready = r_block_ready;
        if (w_load) begin
            if (w_cnt_inc >= w_total) begin
                n_block_ready = 1'b1;
                n_load_cnt    = '0;
            end else begin
                n_load_cnt = AW'(w_cnt_inc);
            end
        end else if (w_stat.consume) begin
            n_block_ready = 1'b0;
            n_load_cnt    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt    <= '0;
            r_block_ready <= 1'b0;
        end else begin
            r_load_cnt    <= n_load_cnt;
            r_block_ready <= n_block_ready;
        end
    end

    dbir_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (r_load_cnt),
        .i_wdata (i_s_tdata),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    dbir_seq #(
        .MAX_CHANNELS    (MAX_CHANNELS),
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
        .MAX_STEP        (MAX_STEP)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_start),
        .i_block_ready (r_block_ready),
        .i_oc          (w_oc),
        .i_st          (w_st),
        .i_bs          (w_bs),
        .i_total       (w_total),
        .i_desc        (r_desc),
        .i_brev        (r_brev),
        .i_dlen        (r_dlen),
        .o_rd_en       (w_rd_en),
        .o_rd_addr     (w_rd_addr),
        .i_rd_data     (w_rd_data),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser),
        .o_m_tlast     (o_m_tlast),
        .o_stat        (w_stat)
    );

    // A read beat always makes the block busy for at least the next cycle
    a_read_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !o_s_tready)
        else $error("input ready right after a read beat");

    // Only a ready block can be consumed
    a_consume_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.consume |-> r_block_ready)
        else $error("block consumed while not ready");

    // A ready block holds no partial fill count
    a_ready_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_block_ready |-> (r_load_cnt == '0))
        else $error("fill count nonzero while block ready");

    // Store is never written while the sequencer reads a frame
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.busy |-> !w_load)
        else $error("store written during a frame read");

endmodule
